FILE: rtl/srtc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtc_pkg
// Shared widths, register indexes, reset values and types of the shading-rate
// tile classifier.
// ----------------------------------------------------------------------------
package srtc_pkg;

    // Port and field widths.
    localparam int TILE_W   = 10;
    localparam int IN_TD_W  = 24;
    localparam int OUT_TD_W = 8;
    localparam int DIR_W    = 48;
    localparam int COMP_W   = 16;
    localparam int PX_W     = 32;
    localparam int HT_W     = 24;
    localparam int TS_W     = 8;
    localparam int VS_W     = 16;
    localparam int TDIM_W   = 16;
    localparam int VDIM_W   = 32;
    localparam int CFG_W    = 48;
    localparam int CFG_IDX_W = 3;

    // Limb width of the pipelined multipliers.
    localparam int LIMB_W = 32;

    localparam int MAX_TILES_DEF = 1024;

    // Datapath widths. The tile-centre offset is in half pixels, its magnitude
    // times the pixel size is rounded to nearest by RND_SH bits, in 2^-24 units.
    localparam int MAG_W  = TILE_W + 1 + TS_W;
    localparam int RND_SH = 9;
    localparam int OFS_W  = MAG_W + PX_W - RND_SH + 1;
    localparam int FWD_SH = 24;
    localparam int PRD_W  = COMP_W + OFS_W;
    localparam int RAY_W  = PRD_W + 1;
    localparam int RMAG_W = RAY_W - 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FWD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RGT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PX   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_THR  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW = 3'd7;

    // Register reset values: forward +z, up +y, right +x, 16x16 tiles,
    // 1920x1080 viewport.
    localparam logic [DIR_W-1:0]  FWD_RST  = 48'h4000_0000_0000;
    localparam logic [DIR_W-1:0]  UP_RST   = 48'h0000_4000_0000;
    localparam logic [DIR_W-1:0]  RGT_RST  = 48'h0000_0000_4000;
    localparam logic [TDIM_W-1:0] TILE_RST = 16'h1010;
    localparam logic [VDIM_W-1:0] VIEW_RST = 32'h0438_0780;

    // Shading rate codes.
    typedef enum logic [1:0] {
        RATE_1X1 = 2'd0,
        RATE_2X2 = 2'd1,
        RATE_4X4 = 2'd2
    } t_rate;

    // Ray leaving the direction stage: downward flag and component magnitudes.
    typedef struct packed {
        logic                   down;
        logic [2:0][RMAG_W-1:0] mag;
    } t_ray;

endpackage

FILE: rtl/srtc_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtc_mul
// Unsigned multiplier in three register stages: limb partial products, row
// sums, final sum.
// ----------------------------------------------------------------------------
module srtc_mul #(
    parameter int WA = 32,
    parameter int WB = 32
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WA-1:0]    i_a,
    input  logic [WB-1:0]    i_b,
    output logic [WA+WB-1:0] o_p
);

    localparam int LW = srtc_pkg::LIMB_W;
    localparam int NA = (WA + LW - 1) / LW;
    localparam int NB = (WB + LW - 1) / LW;
    localparam int PA = NA * LW;
    localparam int PB = NB * LW;
    localparam int RW = (NB + 1) * LW;
    localparam int SW = (NA + NB) * LW;

    logic [PA-1:0]      w_a;
    logic [PB-1:0]      w_b;
    logic [2*LW-1:0]    n_pp [NA][NB];
    logic [2*LW-1:0]    r_pp [NA][NB];
    logic [RW-1:0]      n_row [NA];
    logic [RW-1:0]      r_row [NA];
    logic [SW-1:0]      n_sum;
    logic [WA+WB-1:0]   r_sum;

    assign w_a = PA'(i_a);
    assign w_b = PB'(i_b);

    // Stage 1: one limb-by-limb product per pair.
    always_comb begin
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                n_pp[i][j] = (2*LW)'(w_a[i*LW +: LW]) * (2*LW)'(w_b[j*LW +: LW]);
            end
        end
    end

    // Stage 2: each row of partial products summed at its limb offsets.
    always_comb begin
        for (int i = 0; i < NA; i++) begin
            n_row[i] = '0;
            for (int j = 0; j < NB; j++) begin
                n_row[i] = n_row[i] + (RW'(r_pp[i][j]) << (j * LW));
            end
        end
    end

    // Stage 3: rows summed into the full product.
    always_comb begin
        n_sum = '0;
        for (int i = 0; i < NA; i++) begin
            n_sum = n_sum + (SW'(r_row[i]) << (i * LW));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pp  <= n_pp;
            r_row <= n_row;
            r_sum <= n_sum[WA+WB-1:0];
        end
    end

    assign o_p = r_sum;

endmodule

FILE: rtl/srtc_offset.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtc_offset
// Eight-stage pipeline from a tile index to the signed view-plane offset of
// the tile centre, in units of 2^-24.
// ----------------------------------------------------------------------------
module srtc_offset #(
    parameter int MAX_TILES = srtc_pkg::MAX_TILES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [srtc_pkg::TILE_W-1:0]       i_tile,
    input  logic [srtc_pkg::TS_W-1:0]         i_tsize,
    input  logic [srtc_pkg::VS_W-1:0]         i_vsize,
    input  logic [srtc_pkg::PX_W-1:0]         i_px,
    output logic signed [srtc_pkg::OFS_W-1:0] o_ofs
);

    localparam int TW     = srtc_pkg::TILE_W;
    localparam int RSH    = 2 * TW;
    localparam int RECIP  = (1 << RSH) / MAX_TILES;
    localparam int RCP_W  = RSH + 1;
    localparam int MOD_W  = $clog2(MAX_TILES + 1);
    localparam int QP_W   = TW + RCP_W;
    localparam int QM_W   = TW + MOD_W;
    localparam int CW     = TW + MOD_W;
    localparam int MAG_W  = srtc_pkg::MAG_W;
    localparam int M_W    = MAG_W + srtc_pkg::PX_W;
    localparam int SUM_W  = M_W + 1;
    localparam int RND_SH = srtc_pkg::RND_SH;
    localparam int Q_W    = srtc_pkg::OFS_W - 1;
    localparam int OFS_W  = srtc_pkg::OFS_W;

    localparam logic [RCP_W-1:0] RCP_V = RCP_W'(RECIP);
    localparam logic [MOD_W-1:0] MOD_V = MOD_W'(MAX_TILES);
    localparam logic [SUM_W-1:0] RND_V = SUM_W'(1) << (RND_SH - 1);

    logic [QP_W-1:0]         n_qp;
    logic [TW-1:0]           r1_tile;
    logic [TW-1:0]           r1_q;
    logic [QM_W-1:0]         n_qm;
    logic [TW-1:0]           r2_r0;
    logic [CW-1:0]           n_red;
    logic                    n_ge;
    logic [TW-1:0]           n_tx;
    logic [TW:0]             r3_odd;
    logic [MAG_W-1:0]        r4_prod;
    logic                    n_neg;
    logic [MAG_W-1:0]        r5_mag;
    logic                    r5_neg;
    logic [M_W-1:0]          r6_m;
    logic                    r6_neg;
    logic [SUM_W-1:0]        n_sum;
    logic [Q_W-1:0]          r7_q;
    logic                    r7_neg;
    logic signed [OFS_W-1:0] w_qs;
    logic signed [OFS_W-1:0] r8_ofs;

    // Tile index modulo MAX_TILES: reciprocal estimate, which is low by at
    // most one, then a single corrective subtract.
    always_comb begin
        n_qp  = QP_W'(i_tile) * QP_W'(RCP_V);
        n_qm  = QM_W'(r1_q) * QM_W'(MOD_V);
        n_red = CW'(r2_r0) - CW'(MOD_V);
        n_ge  = CW'(r2_r0) >= CW'(MOD_V);
        n_tx  = n_ge ? n_red[TW-1:0] : r2_r0;
    end

    // Centre offset in half pixels, split into sign and magnitude.
    assign n_neg = r4_prod < MAG_W'(i_vsize);

    // Scale by the pixel size and round to nearest, ties away from zero.
    assign n_sum = SUM_W'(r6_m) + RND_V;
    assign w_qs  = {1'b0, r7_q};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_tile <= i_tile;
            r1_q    <= n_qp[RSH +: TW];
            r2_r0   <= r1_tile - n_qm[TW-1:0];
            r3_odd  <= {n_tx, 1'b1};
            r4_prod <= MAG_W'(r3_odd) * MAG_W'(i_tsize);
            r5_neg  <= n_neg;
            r5_mag  <= n_neg ? MAG_W'(i_vsize) - r4_prod : r4_prod - MAG_W'(i_vsize);
            r6_m    <= M_W'(r5_mag) * M_W'(i_px);
            r6_neg  <= r5_neg;
            r7_q    <= n_sum[RND_SH +: Q_W];
            r7_neg  <= r6_neg;
            r8_ofs  <= r7_neg ? -w_qs : w_qs;
        end
    end

    assign o_ofs = r8_ofs;

endmodule

FILE: rtl/srtc_ray.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtc_ray
// Three-stage pipeline forming the camera ray through the tile centre and
// returning its component magnitudes and whether it points downward.
// ----------------------------------------------------------------------------
module srtc_ray (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [srtc_pkg::OFS_W-1:0] i_dx,
    input  logic signed [srtc_pkg::OFS_W-1:0] i_dy,
    input  logic [srtc_pkg::DIR_W-1:0]        i_fwd,
    input  logic [srtc_pkg::DIR_W-1:0]        i_up,
    input  logic [srtc_pkg::DIR_W-1:0]        i_rgt,
    output srtc_pkg::t_ray                    o_ray
);

    localparam int CW     = srtc_pkg::COMP_W;
    localparam int PRD_W  = srtc_pkg::PRD_W;
    localparam int RAY_W  = srtc_pkg::RAY_W;
    localparam int RMAG_W = srtc_pkg::RMAG_W;

    logic signed [CW-1:0]    w_fc [3];
    logic signed [CW-1:0]    w_uc [3];
    logic signed [CW-1:0]    w_rc [3];
    logic signed [PRD_W-1:0] n_pu [3];
    logic signed [PRD_W-1:0] n_pr [3];
    logic signed [PRD_W-1:0] r1_pu [3];
    logic signed [PRD_W-1:0] r1_pr [3];
    logic signed [RAY_W-1:0] n_r [3];
    logic signed [RAY_W-1:0] r2_r [3];
    srtc_pkg::t_ray          n_ray;
    srtc_pkg::t_ray          r3_ray;

    // Direction components, x lowest.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_fc[i] = i_fwd[i*CW +: CW];
            w_uc[i] = i_up[i*CW +: CW];
            w_rc[i] = i_rgt[i*CW +: CW];
        end
    end

    // Stage 1: up and right vectors scaled by the offsets.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_pu[i] = PRD_W'(w_uc[i]) * PRD_W'(i_dy);
            n_pr[i] = PRD_W'(w_rc[i]) * PRD_W'(i_dx);
        end
    end

    // Stage 2: forward vector brought to the same scale and added in.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_r[i] = (RAY_W'(w_fc[i]) <<< srtc_pkg::FWD_SH) + RAY_W'(r1_pu[i])
                   + RAY_W'(r1_pr[i]);
        end
    end

    // Stage 3: magnitudes and the downward flag.
    always_comb begin
        n_ray.down = r2_r[1][RAY_W-1];
        for (int i = 0; i < 3; i++) begin
            n_ray.mag[i] = r2_r[i][RAY_W-1] ? RMAG_W'(-r2_r[i]) : RMAG_W'(r2_r[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_pu  <= n_pu;
            r1_pr  <= n_pr;
            r2_r   <= n_r;
            r3_ray <= n_ray;
        end
    end

    assign o_ray = r3_ray;

endmodule

FILE: rtl/shading_rate_tile_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shading_rate_tile_classifier
// Classifies one shading-rate tile per word into rate 0, 1 or 2 from the
// ground footprint of the camera ray through the tile centre.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream takes one tile word per cycle while o_s_axis_tready
//   is high: tile_x in bits 9..0 and tile_y in bits 19..10. The master
//   stream returns one rate word per tile, in order, rate in bits 1..0.
//   Camera and viewport registers are to be written through the plain write
//   port only while no tile is in flight; the block itself does not enforce
//   this. Values derived from height, pixel size and threshold are held in
//   r_hp and r_t2, and the squared r_hp passes the free-running u_hp2
//   multiplier. While the skid is empty, throughput is one tile per cycle.
//   The depth is set by the exact squared footprint compare: two 3-stage
//   multiplier trees in series (ray component squares, then the 112 x 120
//   bit product) after the 11-stage offset and ray datapath.
//   When the receiver stalls, the output register holds its word and a skid
//   register takes one more, so the next tile is still accepted; with the
//   skid full, s_axis_tready drops and the whole pipeline holds.
//   Reset clears all valid bits and restores the register defaults: forward
//   +z, up +y, right +x, zero pixel size, height and threshold, 16x16 tiles,
//   1920x1080 viewport.
// ----------------------------------------------------------------------------
module shading_rate_tile_classifier #(
    parameter int MAX_TILES = srtc_pkg::MAX_TILES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Slave stream.
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [srtc_pkg::IN_TD_W-1:0]      i_s_axis_tdata,  // tile_x, tile_y
    // Master stream.
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [srtc_pkg::OUT_TD_W-1:0]     o_m_axis_tdata,  // rate
    // Configuration write port.
    input  logic                              i_cfg_we,
    input  logic [srtc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [srtc_pkg::CFG_W-1:0]        i_cfg_wdata
);

    localparam int TW     = srtc_pkg::TILE_W;
    localparam int DIR_W  = srtc_pkg::DIR_W;
    localparam int PX_W   = srtc_pkg::PX_W;
    localparam int HT_W   = srtc_pkg::HT_W;
    localparam int TS_W   = srtc_pkg::TS_W;
    localparam int VS_W   = srtc_pkg::VS_W;
    localparam int OFS_W  = srtc_pkg::OFS_W;
    localparam int RMAG_W = srtc_pkg::RMAG_W;
    localparam int SQ_W   = 2 * RMAG_W;
    localparam int SS_W   = SQ_W + 2;
    localparam int HP_W   = HT_W + PX_W;
    localparam int HP2_W  = 2 * HP_W;
    localparam int T2_W   = 2 * HT_W;
    localparam int LHS_W  = HP2_W + SS_W;
    localparam int P_W    = T2_W + SQ_W;
    // Twice and four times the threshold, squared, times 2^64.
    localparam int SH2    = 64 + 2;
    localparam int SH4    = 64 + 4;
    localparam int CMP_W  = (P_W + SH4 > LHS_W) ? P_W + SH4 : LHS_W;

    // Stage count up to the last datapath register; the output register
    // follows.
    localparam int NSTG   = 18;
    localparam int DN_W   = 7;

    logic [DIR_W-1:0]                 r_fwd;
    logic [DIR_W-1:0]                 r_up;
    logic [DIR_W-1:0]                 r_rgt;
    logic [PX_W-1:0]                  r_px;
    logic [HT_W-1:0]                  r_ht;
    logic [HT_W-1:0]                  r_thr;
    logic [srtc_pkg::TDIM_W-1:0]      r_tile;
    logic [srtc_pkg::VDIM_W-1:0]      r_view;

    logic [TS_W-1:0]                  w_tw;
    logic [TS_W-1:0]                  w_th;
    logic [VS_W-1:0]                  w_vw;
    logic [VS_W-1:0]                  w_vh;

    logic [HP_W-1:0]                  r_hp;
    logic [HP2_W-1:0]                 w_hp2;
    logic [T2_W-1:0]                  r_t2;

    logic                             w_adv;
    logic [NSTG:1]                    r_vld;
    logic signed [OFS_W-1:0]          w_dx;
    logic signed [OFS_W-1:0]          w_dy;
    srtc_pkg::t_ray                   w_ray;
    logic [SQ_W-1:0]                  w_sq [3];
    logic [SS_W-1:0]                  r_ss;
    logic [SQ_W-1:0]                  r_ry2;
    logic [DN_W-1:0]                  r_down;
    logic [LHS_W-1:0]                 w_lhs;
    logic [P_W-1:0]                   w_p;
    logic                             w_ge2;
    logic                             w_ge4;
    srtc_pkg::t_rate                  w_rate;

    logic                             w_take;
    logic                             r_out_v;
    logic                             n_out_v;
    srtc_pkg::t_rate                  r_out_rate;
    srtc_pkg::t_rate                  n_out_rate;
    logic                             r_skid_v;
    logic                             n_skid_v;
    srtc_pkg::t_rate                  r_skid_rate;
    srtc_pkg::t_rate                  n_skid_rate;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd  <= srtc_pkg::FWD_RST;
            r_up   <= srtc_pkg::UP_RST;
            r_rgt  <= srtc_pkg::RGT_RST;
            r_px   <= '0;
            r_ht   <= '0;
            r_thr  <= '0;
            r_tile <= srtc_pkg::TILE_RST;
            r_view <= srtc_pkg::VIEW_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                srtc_pkg::CFG_FWD:  r_fwd  <= i_cfg_wdata[DIR_W-1:0];
                srtc_pkg::CFG_UP:   r_up   <= i_cfg_wdata[DIR_W-1:0];
                srtc_pkg::CFG_RGT:  r_rgt  <= i_cfg_wdata[DIR_W-1:0];
                srtc_pkg::CFG_PX:   r_px   <= i_cfg_wdata[PX_W-1:0];
                srtc_pkg::CFG_HT:   r_ht   <= i_cfg_wdata[HT_W-1:0];
                srtc_pkg::CFG_THR:  r_thr  <= i_cfg_wdata[HT_W-1:0];
                srtc_pkg::CFG_TILE: r_tile <= i_cfg_wdata[srtc_pkg::TDIM_W-1:0];
                srtc_pkg::CFG_VIEW: r_view <= i_cfg_wdata[srtc_pkg::VDIM_W-1:0];
            endcase
        end
    end

    // A tile or viewport size of zero counts as one.
    always_comb begin
        w_tw = (r_tile[TS_W-1:0] == '0) ? TS_W'(1) : r_tile[TS_W-1:0];
        w_th = (r_tile[2*TS_W-1:TS_W] == '0) ? TS_W'(1) : r_tile[2*TS_W-1:TS_W];
        w_vw = (r_view[VS_W-1:0] == '0) ? VS_W'(1) : r_view[VS_W-1:0];
        w_vh = (r_view[2*VS_W-1:VS_W] == '0) ? VS_W'(1) : r_view[2*VS_W-1:VS_W];
    end

    // Values derived from the registers, recomputed every cycle.
    always_ff @(posedge i_clk) begin
        r_hp <= HP_W'(r_ht) * HP_W'(r_px);
        r_t2 <= T2_W'(r_thr) * T2_W'(r_thr);
    end

    srtc_mul #(.WA(HP_W), .WB(HP_W)) u_hp2 (
        .i_clk (i_clk),
        .i_en  (1'b1),
        .i_a   (r_hp),
        .i_b   (r_hp),
        .o_p   (w_hp2)
    );

    // Pipeline control: the whole pipeline moves unless the skid word is
    // waiting.
    assign w_adv           = !r_skid_v;
    assign o_s_axis_tready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NSTG-1:1], i_s_axis_tvalid};
        end
    end

    // Stages 1 to 8: tile-centre offsets.
    srtc_offset #(.MAX_TILES(MAX_TILES)) u_ofs_x (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_tile  (i_s_axis_tdata[TW-1:0]),
        .i_tsize (w_tw),
        .i_vsize (w_vw),
        .i_px    (r_px),
        .o_ofs   (w_dx)
    );

    srtc_offset #(.MAX_TILES(MAX_TILES)) u_ofs_y (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_tile  (i_s_axis_tdata[2*TW-1:TW]),
        .i_tsize (w_th),
        .i_vsize (w_vh),
        .i_px    (r_px),
        .o_ofs   (w_dy)
    );

    // Stages 9 to 11: ray through the tile centre.
    srtc_ray u_ray (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_dx  (w_dx),
        .i_dy  (w_dy),
        .i_fwd (r_fwd),
        .i_up  (r_up),
        .i_rgt (r_rgt),
        .o_ray (w_ray)
    );

    // Stages 12 to 14: squared ray components.
    for (genvar g = 0; g < 3; g++) begin : g_sq
        srtc_mul #(.WA(RMAG_W), .WB(RMAG_W)) u_sq (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_a   (w_ray.mag[g]),
            .i_b   (w_ray.mag[g]),
            .o_p   (w_sq[g])
        );
    end

    // Stage 15: squared ray length; the squared y component travels alongside.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ss   <= SS_W'(w_sq[0]) + SS_W'(w_sq[1]) + SS_W'(w_sq[2]);
            r_ry2  <= w_sq[1];
            r_down <= {r_down[DN_W-2:0], w_ray.down};
        end
    end

    // Stages 16 to 18: both sides of the squared footprint compare.
    srtc_mul #(.WA(HP2_W), .WB(SS_W)) u_lhs (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_a   (w_hp2),
        .i_b   (r_ss),
        .o_p   (w_lhs)
    );

    srtc_mul #(.WA(T2_W), .WB(SQ_W)) u_rhs (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_a   (r_t2),
        .i_b   (r_ry2),
        .o_p   (w_p)
    );

    // Footprint against 2x and 4x the threshold; a ray not downward gets 4x4.
    always_comb begin
        w_ge2 = CMP_W'(w_lhs) >= (CMP_W'(w_p) << SH2);
        w_ge4 = CMP_W'(w_lhs) >= (CMP_W'(w_p) << SH4);
        if (!r_down[DN_W-1] || w_ge4) begin
            w_rate = srtc_pkg::RATE_4X4;
        end else if (w_ge2) begin
            w_rate = srtc_pkg::RATE_2X2;
        end else begin
            w_rate = srtc_pkg::RATE_1X1;
        end
    end

    // Output register with one skid word behind it.
    always_comb begin
        n_out_v     = r_out_v;
        n_out_rate  = r_out_rate;
        n_skid_v    = r_skid_v;
        n_skid_rate = r_skid_rate;
        w_take      = r_out_v && i_m_axis_tready;
        if (r_skid_v) begin
            if (w_take) begin
                n_out_rate = r_skid_rate;
                n_skid_v   = 1'b0;
            end
        end else if (!r_out_v || w_take) begin
            n_out_v    = r_vld[NSTG];
            n_out_rate = w_rate;
        end else if (r_vld[NSTG]) begin
            n_skid_v    = 1'b1;
            n_skid_rate = w_rate;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
        r_out_rate  <= n_out_rate;
        r_skid_rate <= n_skid_rate;
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = srtc_pkg::OUT_TD_W'(r_out_rate);

`ifndef SYNTHESIS
    // A skid word only exists behind a valid output word.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid word held without an output word");

    // The skid fills only when the output word was stalled.
    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && !i_m_axis_tready))
        else $error("skid filled without a stall");

    // With the skid full the pipeline holds every stage.
    a_pipe_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |=> $stable(r_vld))
        else $error("pipeline moved while the skid was full");

    // The four-times bound can only be met if the two-times bound is.
    a_bounds_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NSTG] && w_ge4) |-> w_ge2)
        else $error("footprint compare bounds out of order");
`endif

endmodule
